### rtl/ucep_pkg.sv
package ucep_pkg;

  // Event codes carried by in_mode
  typedef enum logic [2:0] {
    MODE_BUS_RESET   = 3'd0,
    MODE_SETUP       = 3'd1,
    MODE_IN_DONE     = 3'd2,
    MODE_OUT_DONE    = 3'd3,
    MODE_CLASS_IN    = 3'd4,
    MODE_CLASS_OUT   = 3'd5,
    MODE_CLASS_ZLP   = 3'd6,
    MODE_CLASS_STALL = 3'd7
  } ucep_mode_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_STALL    = 4'd1,
    ACT_DATA_IN  = 4'd2,
    ACT_ZLP      = 4'd3,
    ACT_ARM_OUT  = 4'd4,
    ACT_TO_CLASS = 4'd5,
    ACT_SET_ADDR = 4'd6,
    ACT_OUT_DONE = 4'd7,
    ACT_RESET    = 4'd8
  } ucep_action_t;

  typedef enum logic [3:0] {
    SRC_DEVICE   = 4'd0,
    SRC_CONFIG   = 4'd1,
    SRC_LANGID   = 4'd2,
    SRC_MANUF    = 4'd3,
    SRC_PRODUCT  = 4'd4,
    SRC_SERIAL   = 4'd5,
    SRC_STATUS   = 4'd6,
    SRC_CONFBYTE = 4'd7,
    SRC_IFACE    = 4'd8,
    SRC_CLASS    = 4'd9
  } ucep_source_t;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_DATA_IN    = 3'd1,
    ST_DATA_OUT   = 3'd2,
    ST_STATUS_IN  = 3'd3,
    ST_STATUS_OUT = 3'd4,
    ST_PEND_ADDR  = 3'd5
  } ucep_stage_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEVICE_LEN  = 3'd0,
    CFG_CONFIG_LEN  = 3'd1,
    CFG_LANGID_LEN  = 3'd2,
    CFG_MANUF_LEN   = 3'd3,
    CFG_PRODUCT_LEN = 3'd4,
    CFG_SERIAL_LEN  = 3'd5
  } ucep_cfg_index_t;

  // bmRequestType kind field
  localparam logic [7:0] REQ_KIND_MASK     = 8'h60;
  localparam logic [7:0] REQ_KIND_STANDARD = 8'h00;
  localparam logic [7:0] REQ_KIND_CLASS    = 8'h20;

  // Standard request codes
  localparam logic [7:0] STD_STATUS_RD   = 8'h00;
  localparam logic [7:0] STD_FEATURE_CLR = 8'h01;
  localparam logic [7:0] STD_FEATURE_SET = 8'h03;
  localparam logic [7:0] STD_ADDR_WR     = 8'h05;
  localparam logic [7:0] STD_DESC_RD     = 8'h06;
  localparam logic [7:0] STD_CONF_RD     = 8'h08;
  localparam logic [7:0] STD_CONF_WR     = 8'h09;
  localparam logic [7:0] STD_IFACE_RD    = 8'h0A;
  localparam logic [7:0] STD_IFACE_WR    = 8'h0B;

  // Descriptor types and string indexes
  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;
  localparam logic [7:0] STR_LANGID  = 8'h00;
  localparam logic [7:0] STR_MANUF   = 8'h01;
  localparam logic [7:0] STR_PRODUCT = 8'h02;
  localparam logic [7:0] STR_SERIAL  = 8'h03;

  // Fixed reply lengths
  localparam logic [15:0] LEN_STATUS   = 16'd2;
  localparam logic [15:0] LEN_ONE_BYTE = 16'd1;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  typedef struct packed {
    ucep_stage_t stage;
    logic [6:0]  pend_addr;
    logic [6:0]  addr;
    logic [7:0]  conf;
    logic        class_out;
  } ucep_state_t;

  typedef struct packed {
    logic [7:0]  device_len;
    logic [15:0] config_len;
    logic [7:0]  langid_len;
    logic [7:0]  manuf_len;
    logic [7:0]  product_len;
    logic [7:0]  serial_len;
  } ucep_lens_t;

  typedef struct packed {
    ucep_action_t action;
    ucep_source_t source;
    logic [15:0]  length;
    logic         multi;
    logic [6:0]   addr;
    logic [7:0]   conf;
    logic         configured;
    logic         rearm;
    ucep_stage_t  stage;
    logic         last;
  } ucep_result_t;

endpackage

### rtl/usb_control_endpoint_handler_unit.sv
// A result word is queued when its event is accepted and is offered on out_* from the queue head.
// Throughput: one event per cycle while in_ready is high; an event that yields two words occupies
// the single output port for both words; a four-word result queue sets how far input runs ahead.
// in_ready depends only on queue fill (room for two words), never on out_ready.
// Reset (rst_n low, synchronous): control state cleared, descriptor lengths back to
// their defaults, result queue emptied.
module usb_control_endpoint_handler_unit import ucep_pkg::*; #(
  parameter int unsigned EP0_PACKET_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_request_type,
  input  logic [7:0]  in_request_code,
  input  logic [15:0] in_request_value,
  input  logic [15:0] in_request_length,
  input  logic [15:0] in_class_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_action,
  output logic [3:0]  out_data_source,
  output logic [15:0] out_transfer_length,
  output logic        out_multi_packet,
  output logic [6:0]  out_device_address,
  output logic [7:0]  out_configuration_value,
  output logic        out_configured,
  output logic        out_rearm_bulk_out,
  output logic [2:0]  out_control_stage,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  ucep_state_t  state_r, state_nxt;
  ucep_lens_t   lens_r;
  ucep_result_t res_first, res_second, head;
  logic         two_results;
  logic         in_fire, out_fire;
  logic [PTR_W:0] fill;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (fill <= (PTR_W+1)'(FIFO_DEPTH - 2));

  // Descriptor length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lens_r.device_len  <= 8'd18;
      lens_r.config_len  <= 16'd67;
      lens_r.langid_len  <= 8'd4;
      lens_r.manuf_len   <= 8'd0;
      lens_r.product_len <= 8'd0;
      lens_r.serial_len  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEVICE_LEN:  lens_r.device_len  <= cfg_wdata[7:0];
        CFG_CONFIG_LEN:  lens_r.config_len  <= cfg_wdata;
        CFG_LANGID_LEN:  lens_r.langid_len  <= cfg_wdata[7:0];
        CFG_MANUF_LEN:   lens_r.manuf_len   <= cfg_wdata[7:0];
        CFG_PRODUCT_LEN: lens_r.product_len <= cfg_wdata[7:0];
        CFG_SERIAL_LEN:  lens_r.serial_len  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ucep_decode #(
    .EP0_PACKET_BYTES(EP0_PACKET_BYTES)
  ) u_decode (
    .mode          (in_mode),
    .request_type  (in_request_type),
    .request_code  (in_request_code),
    .request_value (in_request_value),
    .request_length(in_request_length),
    .class_length  (in_class_length),
    .cur           (state_r),
    .lens          (lens_r),
    .nxt           (state_nxt),
    .res_first     (res_first),
    .res_second    (res_second),
    .two_results   (two_results)
  );

  // Commit control state on each accepted event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.stage     <= ST_IDLE;
      state_r.pend_addr <= '0;
      state_r.addr      <= '0;
      state_r.conf      <= '0;
      state_r.class_out <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  ucep_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_two   (two_results),
    .push_first (res_first),
    .push_second(res_second),
    .pop        (out_fire),
    .head_valid (out_valid),
    .head       (head),
    .count      (fill)
  );

  assign out_action              = head.action;
  assign out_data_source         = head.source;
  assign out_transfer_length     = head.length;
  assign out_multi_packet        = head.multi;
  assign out_device_address      = head.addr;
  assign out_configuration_value = head.conf;
  assign out_configured          = head.configured;
  assign out_rearm_bulk_out      = head.rearm;
  assign out_control_stage       = head.stage;
  assign out_last                = head.last;

`ifndef NO_ASSERTIONS
  // The queue never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= (PTR_W+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A word that is not the last of its event is always followed by another
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last |=> out_valid)
    else $error("second result word missing");

  // The applied address moves only on IN done or bus reset
  a_addr_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(state_r.addr) |->
      ($past(!rst_n) || $past(in_fire && (in_mode == MODE_IN_DONE ||
                                           in_mode == MODE_BUS_RESET))))
    else $error("device address changed without cause");
`endif

endmodule

### rtl/ucep_decode.sv
module ucep_decode import ucep_pkg::*; #(
  parameter int unsigned EP0_PACKET_BYTES = 64
) (
  input  logic [2:0]   mode,
  input  logic [7:0]   request_type,
  input  logic [7:0]   request_code,
  input  logic [15:0]  request_value,
  input  logic [15:0]  request_length,
  input  logic [15:0]  class_length,
  input  ucep_state_t  cur,
  input  ucep_lens_t   lens,
  output ucep_state_t  nxt,
  output ucep_result_t res_first,
  output ucep_result_t res_second,
  output logic         two_results
);

  localparam logic [15:0] PKT_BYTES = 16'(EP0_PACKET_BYTES);

  ucep_action_t act;
  ucep_source_t src;
  logic [15:0]  raw_len;
  logic [15:0]  len;
  logic         multi;
  logic         rearm;
  ucep_result_t main_res;
  ucep_result_t done_res;

  // Decode one event into the main action and the next state
  always_comb begin
    act         = ACT_NONE;
    src         = SRC_DEVICE;
    raw_len     = '0;
    rearm       = 1'b0;
    two_results = 1'b0;
    nxt         = cur;
    case (mode)
      MODE_BUS_RESET: begin
        nxt.stage     = ST_IDLE;
        nxt.pend_addr = '0;
        nxt.addr      = '0;
        nxt.conf      = '0;
        nxt.class_out = 1'b0;
        act           = ACT_RESET;
      end
      MODE_SETUP: begin
        if ((request_type & REQ_KIND_MASK) == REQ_KIND_STANDARD) begin
          case (request_code)
            STD_DESC_RD: begin
              case (request_value[15:8])
                DESC_DEVICE: begin
                  act = ACT_DATA_IN; src = SRC_DEVICE; raw_len = {8'd0, lens.device_len};
                end
                DESC_CONFIG: begin
                  act = ACT_DATA_IN; src = SRC_CONFIG; raw_len = lens.config_len;
                end
                DESC_STRING: begin
                  case (request_value[7:0])
                    STR_LANGID: begin
                      act = ACT_DATA_IN; src = SRC_LANGID; raw_len = {8'd0, lens.langid_len};
                    end
                    STR_MANUF: begin
                      act = ACT_DATA_IN; src = SRC_MANUF; raw_len = {8'd0, lens.manuf_len};
                    end
                    STR_PRODUCT: begin
                      act = ACT_DATA_IN; src = SRC_PRODUCT;
                      raw_len = {8'd0, lens.product_len};
                    end
                    STR_SERIAL: begin
                      act = ACT_DATA_IN; src = SRC_SERIAL; raw_len = {8'd0, lens.serial_len};
                    end
                    default: act = ACT_STALL;
                  endcase
                end
                default: act = ACT_STALL;
              endcase
            end
            STD_ADDR_WR: begin
              nxt.pend_addr = request_value[6:0];
              act           = ACT_ZLP;
            end
            STD_CONF_RD: begin
              act = ACT_DATA_IN; src = SRC_CONFBYTE; raw_len = LEN_ONE_BYTE;
            end
            STD_CONF_WR: begin
              nxt.conf = request_value[7:0];
              act      = ACT_ZLP;
              rearm    = 1'b1;
            end
            STD_STATUS_RD: begin
              act = ACT_DATA_IN; src = SRC_STATUS; raw_len = LEN_STATUS;
            end
            STD_FEATURE_CLR, STD_FEATURE_SET, STD_IFACE_WR: act = ACT_ZLP;
            STD_IFACE_RD: begin
              act = ACT_DATA_IN; src = SRC_IFACE; raw_len = LEN_ONE_BYTE;
            end
            default: act = ACT_STALL;
          endcase
          // Stage follows the action; an address request waits for its status stage
          if (request_code == STD_ADDR_WR) begin
            nxt.stage = ST_PEND_ADDR;
          end else if (act == ACT_ZLP) begin
            nxt.stage = ST_STATUS_IN;
          end else if (act == ACT_DATA_IN) begin
            nxt.stage = ST_DATA_IN;
          end else begin
            nxt.stage = ST_IDLE;
          end
        end else if ((request_type & REQ_KIND_MASK) == REQ_KIND_CLASS) begin
          act = ACT_TO_CLASS;
        end else begin
          act       = ACT_STALL;
          nxt.stage = ST_IDLE;
        end
      end
      MODE_IN_DONE: begin
        if (cur.stage == ST_DATA_IN) begin
          nxt.stage = ST_STATUS_OUT;
        end else if (cur.stage == ST_PEND_ADDR) begin
          nxt.addr      = cur.pend_addr;
          nxt.pend_addr = '0;
          nxt.stage     = ST_IDLE;
          act           = ACT_SET_ADDR;
        end else begin
          nxt.stage = ST_IDLE;
        end
      end
      MODE_OUT_DONE: begin
        if (cur.stage == ST_DATA_OUT) begin
          two_results   = cur.class_out;
          nxt.class_out = 1'b0;
          nxt.stage     = ST_STATUS_IN;
          act           = ACT_ZLP;
        end else begin
          nxt.stage = ST_IDLE;
        end
      end
      MODE_CLASS_IN: begin
        act       = ACT_DATA_IN;
        src       = SRC_CLASS;
        raw_len   = class_length;
        nxt.stage = ST_DATA_IN;
      end
      MODE_CLASS_OUT: begin
        act           = ACT_ARM_OUT;
        src           = SRC_CLASS;
        raw_len       = class_length;
        nxt.stage     = ST_DATA_OUT;
        nxt.class_out = 1'b1;
      end
      MODE_CLASS_ZLP: begin
        act       = ACT_ZLP;
        nxt.stage = ST_STATUS_IN;
      end
      default: begin
        act       = ACT_STALL;
        nxt.stage = ST_IDLE;
      end
    endcase
  end

  // Clamp data in to wLength and flag multi-packet transfers
  always_comb begin
    len = raw_len;
    if (act == ACT_DATA_IN && raw_len > request_length) begin
      len = request_length;
    end
    multi = (act == ACT_DATA_IN || act == ACT_ARM_OUT) && (len > PKT_BYTES);
  end

  // Build the result words; status fields show the state after the event (before it for the out-done word)
  always_comb begin
    main_res.action     = act;
    main_res.source     = src;
    main_res.length     = len;
    main_res.multi      = multi;
    main_res.addr       = nxt.addr;
    main_res.conf       = nxt.conf;
    main_res.configured = (nxt.conf != 8'd0);
    main_res.rearm      = rearm;
    main_res.stage      = nxt.stage;
    main_res.last       = 1'b1;

    done_res.action     = ACT_OUT_DONE;
    done_res.source     = SRC_DEVICE;
    done_res.length     = '0;
    done_res.multi      = 1'b0;
    done_res.addr       = cur.addr;
    done_res.conf       = cur.conf;
    done_res.configured = (cur.conf != 8'd0);
    done_res.rearm      = 1'b0;
    done_res.stage      = cur.stage;
    done_res.last       = 1'b0;

    res_first  = two_results ? done_res : main_res;
    res_second = main_res;
  end

endmodule

### rtl/ucep_out_fifo.sv
module ucep_out_fifo import ucep_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic         push_two,
  input  ucep_result_t push_first,
  input  ucep_result_t push_second,
  input  logic         pop,
  output logic         head_valid,
  output ucep_result_t head,
  output logic [PTR_W:0] count
);

  ucep_result_t   mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_second;
  logic [PTR_W:0]   push_cnt;

  assign wr_ptr_second = wr_ptr_r + 1'b1;
  assign push_cnt      = push ? (push_two ? (PTR_W+1)'(2) : (PTR_W+1)'(1)) : '0;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt[PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + {{(PTR_W-1){1'b0}}, pop};
    count_nxt  = count_r + push_cnt - {{PTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store result words; payload needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_first;
      if (push_two) begin
        mem_r[wr_ptr_second] <= push_second;
      end
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

endmodule
